/* rtl/fvng_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fvng_pkg
// Shared constants and types for the fractal value noise gradient pipeline.
// ============================================================================
package fvng_pkg;

    // Default octave count and difference step
    localparam int OCTAVES_DEFAULT = 4;
    localparam int STEP_W          = 21;
    localparam logic [STEP_W-1:0] STEP_RESET = 21'd52429;

    // Sample positions: Q16.16 plus/minus step, 34 bit signed
    localparam int POS_W   = 34;
    // Lattice / octave value width (Q0.24)
    localparam int LAT_W   = 24;
    // Fractal sum width (Q0.32)
    localparam int SUM_W   = 32;
    // Center plus four offset samples
    localparam int NPOINTS = 5;

    // Hash constants
    localparam logic [31:0] HASH_SEED = 32'd61;
    localparam logic [31:0] HASH_KX   = 32'd73856093;
    localparam logic [31:0] HASH_KY   = 32'd19349663;
    localparam logic [31:0] HASH_KMIX = 32'h27d4eb2d;

    // Sideband that rides along the root and divide pipelines
    typedef struct packed {
        logic [30:0] ax;
        logic [30:0] ay;
        logic        nx;
        logic        ny;
        logic        flat;
        logic [15:0] nv;
    } grad_side_t;

endpackage
`default_nettype wire

/* rtl/fvng_octave.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fvng_octave
// One octave of bilinear value noise at one point, five register stages.
// ============================================================================
module fvng_octave
    import fvng_pkg::*;
#(
    parameter int SHIFT = 0
)(
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    output logic [LAT_W-1:0]             octave_value
);

    // hash front half: seed, fold, times 9, fold
    function automatic logic [31:0] mix_front(input logic [31:0] h);
        logic [31:0] v;
        v = h ^ HASH_SEED;
        v = v ^ (v >> 16);
        v = v + (v << 3);
        v = v ^ (v >> 4);
        return v;
    endfunction

    // linear blend, round half up, Q0.24
    function automatic logic [LAT_W-1:0] blend(input logic [LAT_W-1:0] a,
                                               input logic [LAT_W-1:0] b,
                                               input logic [16:0] w);
        logic [41:0] acc;
        acc = 42'(a) * 42'(17'h10000 - w) + 42'(b) * 42'(w) + 42'd32768;
        return acc[39:16];
    endfunction

    logic signed [47:0] sx_ext, sy_ext;
    logic [47:0]        sx_sh, sy_sh;
    logic [31:0]        cx, cy;
    logic [15:0]        tx, ty;

    // stage A
    logic [31:0] kx0_reg, kx1_reg, ky0_reg, ky1_reg;
    logic [31:0] ttx_reg, tty_reg;
    logic [15:0] tx_reg, ty_reg;
    // stage B
    logic [31:0] m_reg [4];
    logic [49:0] pu_reg, pv_reg;
    // stage C
    logic [31:0] m2_reg [4];
    logic [16:0] su_reg, sv_reg;
    // stage D
    logic [LAT_W-1:0] lo_reg, hi_reg;
    logic [16:0]      sv_d_reg;
    logic [LAT_W-1:0] lat [4];
    // stage E
    logic [LAT_W-1:0] oct_reg;

    // Scale by 2^SHIFT, split cell and fraction
    assign sx_ext = 48'(pos_x);
    assign sy_ext = 48'(pos_y);
    assign sx_sh  = sx_ext << SHIFT;
    assign sy_sh  = sy_ext << SHIFT;
    assign cx     = sx_sh[47:16];
    assign cy     = sy_sh[47:16];
    assign tx     = sx_sh[15:0];
    assign ty     = sy_sh[15:0];

    // Lattice values from hashed products
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            lat[k] = LAT_W'(m2_reg[k] ^ (m2_reg[k] >> 15));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A: coordinate products, t squared
            kx0_reg <= cx * HASH_KX;
            kx1_reg <= (cx + 32'd1) * HASH_KX;
            ky0_reg <= cy * HASH_KY;
            ky1_reg <= (cy + 32'd1) * HASH_KY;
            ttx_reg <= {16'b0, tx} * {16'b0, tx};
            tty_reg <= {16'b0, ty} * {16'b0, ty};
            tx_reg  <= tx;
            ty_reg  <= ty;
            // B: corner hash front, smoothstep product
            m_reg[0] <= mix_front(kx0_reg ^ ky0_reg);
            m_reg[1] <= mix_front(kx1_reg ^ ky0_reg);
            m_reg[2] <= mix_front(kx0_reg ^ ky1_reg);
            m_reg[3] <= mix_front(kx1_reg ^ ky1_reg);
            pu_reg   <= 50'(ttx_reg) * 50'(18'h30000 - {1'b0, tx_reg, 1'b0});
            pv_reg   <= 50'(tty_reg) * 50'(18'h30000 - {1'b0, ty_reg, 1'b0});
            // C: hash multiply, smoothstep rounding
            for (int k = 0; k < 4; k++)
            begin
                m2_reg[k] <= m_reg[k] * HASH_KMIX;
            end
            su_reg <= 17'((pu_reg + 50'h0_8000_0000) >> 32);
            sv_reg <= 17'((pv_reg + 50'h0_8000_0000) >> 32);
            // D: blend along x
            lo_reg   <= blend(lat[0], lat[1], su_reg);
            hi_reg   <= blend(lat[2], lat[3], su_reg);
            sv_d_reg <= sv_reg;
            // E: blend along y
            oct_reg  <= blend(lo_reg, hi_reg, sv_d_reg);
        end
    end

    assign octave_value = oct_reg;

endmodule
`default_nettype wire

/* rtl/fvng_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fvng_isqrt
// Pipelined integer square root, one result bit per stage, 32 stages.
// ============================================================================
module fvng_isqrt
    import fvng_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [63:0] in_radicand,
    input  wire grad_side_t  in_side,
    output logic             out_valid,
    output logic [31:0]      out_root,
    output grad_side_t       out_side
);

    localparam int STEPS = 32;

    logic [63:0] rem_reg   [STEPS];
    logic [63:0] root_reg  [STEPS];
    grad_side_t  side_reg  [STEPS];
    logic        vld_reg   [STEPS];

    logic [63:0] rem_in    [STEPS];
    logic [63:0] root_in   [STEPS];
    logic [63:0] trial     [STEPS];
    logic [63:0] bitv      [STEPS];
    logic [63:0] rem_next  [STEPS];
    logic [63:0] root_next [STEPS];

    // One digit per stage
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            rem_in[k]  = (k == 0) ? in_radicand : rem_reg[(k == 0) ? 0 : k - 1];
            root_in[k] = (k == 0) ? 64'd0 : root_reg[(k == 0) ? 0 : k - 1];
            bitv[k]    = 64'd1 << (62 - 2 * k);
            trial[k]   = root_in[k] + bitv[k];
            if (rem_in[k] >= trial[k])
            begin
                rem_next[k]  = rem_in[k] - trial[k];
                root_next[k] = (root_in[k] >> 1) + bitv[k];
            end
            else
            begin
                rem_next[k]  = rem_in[k];
                root_next[k] = root_in[k] >> 1;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_root  = root_reg[STEPS-1][31:0];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

/* rtl/fvng_norm.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fvng_norm
// Rounded division of both gradient magnitudes by the length, restoring
// divide, one quotient bit per stage, 16 stages.
// ============================================================================
module fvng_norm
    import fvng_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire logic [31:0] in_len,
    input  wire grad_side_t  in_side,
    output logic             out_valid,
    output logic [15:0]      out_mag_x,
    output logic [15:0]      out_mag_y,
    output grad_side_t       out_side
);

    localparam int STEPS = 16;

    logic [31:0] len_fix;
    logic [47:0] rx_init, ry_init;

    logic [47:0] rx_reg  [STEPS];
    logic [47:0] ry_reg  [STEPS];
    logic [15:0] qx_reg  [STEPS];
    logic [15:0] qy_reg  [STEPS];
    logic [31:0] len_reg [STEPS];
    grad_side_t  side_reg [STEPS];
    logic        vld_reg [STEPS];

    logic [47:0] rx_in   [STEPS];
    logic [47:0] ry_in   [STEPS];
    logic [15:0] qx_in   [STEPS];
    logic [15:0] qy_in   [STEPS];
    logic [31:0] len_in  [STEPS];
    logic [47:0] dsh     [STEPS];
    logic        gex     [STEPS];
    logic        gey     [STEPS];
    logic [47:0] rx_next [STEPS];
    logic [47:0] ry_next [STEPS];

    // Numerator mag * 2^15 + len / 2; length never zero
    assign len_fix = (in_len == 32'd0) ? 32'd1 : in_len;
    assign rx_init = (48'(in_side.ax) << 15) + 48'(len_fix >> 1);
    assign ry_init = (48'(in_side.ay) << 15) + 48'(len_fix >> 1);

    // Quotient bit 15-k at stage k
    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            rx_in[k]  = (k == 0) ? rx_init : rx_reg[(k == 0) ? 0 : k - 1];
            ry_in[k]  = (k == 0) ? ry_init : ry_reg[(k == 0) ? 0 : k - 1];
            qx_in[k]  = (k == 0) ? 16'd0 : qx_reg[(k == 0) ? 0 : k - 1];
            qy_in[k]  = (k == 0) ? 16'd0 : qy_reg[(k == 0) ? 0 : k - 1];
            len_in[k] = (k == 0) ? len_fix : len_reg[(k == 0) ? 0 : k - 1];
            dsh[k]    = 48'(len_in[k]) << (STEPS - 1 - k);
            gex[k]    = rx_in[k] >= dsh[k];
            gey[k]    = ry_in[k] >= dsh[k];
            rx_next[k] = gex[k] ? rx_in[k] - dsh[k] : rx_in[k];
            ry_next[k] = gey[k] ? ry_in[k] - dsh[k] : ry_in[k];
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                rx_reg[k]   <= rx_next[k];
                ry_reg[k]   <= ry_next[k];
                qx_reg[k]   <= {qx_in[k][14:0], gex[k]};
                qy_reg[k]   <= {qy_in[k][14:0], gey[k]};
                len_reg[k]  <= len_in[k];
                side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign out_valid = vld_reg[STEPS-1];
    assign out_mag_x = qx_reg[STEPS-1];
    assign out_mag_y = qy_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

/* rtl/fbm_value_noise_gradient.sv */
`timescale 1ns / 1ps
`default_nettype none
// The pipeline has 60 register stages: input, offsets, 5 octave stages,
//   sum, difference, square, add, 32 root stages, 16 divide stages, output.
// Throughput: one beat per cycle; the whole pipeline advances unless the
//   output beat is held by out_stall.
// Reset: rst_n clears all valid bits and loads step_reg with 52429.
// ============================================================================
// fbm_value_noise_gradient
// Fractal value noise and its normalized central-difference gradient for a
// Q16.16 point.
// ============================================================================
module fbm_value_noise_gradient
    import fvng_pkg::*;
#(
    parameter int OCTAVES = OCTAVES_DEFAULT
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [STEP_W-1:0]  cfg_wr_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] x_coord,
    input  wire logic signed [31:0] y_coord,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [15:0]             noise_value,
    output logic signed [15:0]      grad_x,
    output logic signed [15:0]      grad_y
);

    // Sample point order
    localparam int PT_CENTER = 0;
    localparam int PT_XP     = 1;
    localparam int PT_XM     = 2;
    localparam int PT_YP     = 3;
    localparam int PT_YM     = 4;
    // Stages ahead of the root unit
    localparam int PRE_STAGES = 11;

    logic pipe_en;

    logic [STEP_W-1:0] step_reg;
    logic              vld_reg [PRE_STAGES];

    logic signed [31:0]      x_reg, y_reg;
    logic signed [POS_W-1:0] px_reg [NPOINTS];
    logic signed [POS_W-1:0] py_reg [NPOINTS];
    logic signed [POS_W-1:0] xe, ye, xp_pos, xm_pos, yp_pos, ym_pos;

    logic [LAT_W-1:0] oct_val [NPOINTS][OCTAVES];
    logic [SUM_W-1:0] sum_next [NPOINTS];
    logic [SUM_W-1:0] sum_reg  [NPOINTS];

    logic [31:0] ax_reg, ay_reg;
    logic        nx_reg, ny_reg;
    logic [15:0] nv_reg;
    logic [16:0] nv_round;

    logic        halve;
    grad_side_t  sq_side_next, sq_side_reg, ssq_side_reg;
    logic [61:0] sqx_reg, sqy_reg;
    logic [63:0] ssq_reg;

    logic        rt_valid;
    logic [31:0] rt_root;
    grad_side_t  rt_side;

    logic        nm_valid;
    logic [15:0] nm_mag_x, nm_mag_y;
    grad_side_t  nm_side;

    logic               out_valid_reg;
    logic [15:0]        nv_out_reg;
    logic signed [15:0] gx_out_reg, gy_out_reg;
    logic               flat_out_reg;
    logic [15:0]        gx_next, gy_next;

    // Whole pipeline moves unless the output beat is held
    assign pipe_en  = !(out_valid_reg && out_stall);
    assign in_stall = !pipe_en;

    // Difference step register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            step_reg <= cfg_wr_data;
        end
    end

    // Valid bits ahead of the root unit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PRE_STAGES; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (pipe_en)
        begin
            for (int k = 0; k < PRE_STAGES; k++)
            begin
                vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    // Offset sample positions
    assign xe     = POS_W'(x_reg);
    assign ye     = POS_W'(y_reg);
    assign xp_pos = xe + POS_W'(step_reg);
    assign xm_pos = xe - POS_W'(step_reg);
    assign yp_pos = ye + POS_W'(step_reg);
    assign ym_pos = ye - POS_W'(step_reg);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            x_reg <= x_coord;
            y_reg <= y_coord;
            px_reg[PT_CENTER] <= xe;
            py_reg[PT_CENTER] <= ye;
            px_reg[PT_XP]     <= xp_pos;
            py_reg[PT_XP]     <= ye;
            px_reg[PT_XM]     <= xm_pos;
            py_reg[PT_XM]     <= ye;
            px_reg[PT_YP]     <= xe;
            py_reg[PT_YP]     <= yp_pos;
            px_reg[PT_YM]     <= xe;
            py_reg[PT_YM]     <= ym_pos;
        end
    end

    // Octave units, one per point and octave
    for (genvar p = 0; p < NPOINTS; p++)
    begin : g_point
        for (genvar i = 0; i < OCTAVES; i++)
        begin : g_oct
            fvng_octave #(
                .SHIFT (i)
            ) u_octave (
                .clk          (clk),
                .en           (pipe_en),
                .pos_x        (px_reg[p]),
                .pos_y        (py_reg[p]),
                .octave_value (oct_val[p][i])
            );
        end
    end

    // Octave sum, weight 2^-(i+1) in Q0.32
    always_comb
    begin
        for (int p = 0; p < NPOINTS; p++)
        begin
            sum_next[p] = '0;
            for (int i = 0; i < OCTAVES; i++)
            begin
                sum_next[p] = sum_next[p] + (SUM_W'(oct_val[p][i]) << (7 - i));
            end
        end
    end

    assign nv_round = 17'((33'(sum_reg[PT_CENTER]) + 33'd32768) >> 16);

    // Halve both differences when either needs 32 bits
    always_comb
    begin
        halve = ax_reg[31] | ay_reg[31];
        sq_side_next.ax   = halve ? ax_reg[31:1] : ax_reg[30:0];
        sq_side_next.ay   = halve ? ay_reg[31:1] : ay_reg[30:0];
        sq_side_next.nx   = nx_reg;
        sq_side_next.ny   = ny_reg;
        sq_side_next.flat = (ax_reg == 32'd0) && (ay_reg == 32'd0);
        sq_side_next.nv   = nv_reg;
    end

    // Sum, difference, square, add
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int p = 0; p < NPOINTS; p++)
            begin
                sum_reg[p] <= sum_next[p];
            end
            nx_reg <= sum_reg[PT_XP] < sum_reg[PT_XM];
            ny_reg <= sum_reg[PT_YP] < sum_reg[PT_YM];
            ax_reg <= (sum_reg[PT_XP] < sum_reg[PT_XM]) ?
                      sum_reg[PT_XM] - sum_reg[PT_XP] : sum_reg[PT_XP] - sum_reg[PT_XM];
            ay_reg <= (sum_reg[PT_YP] < sum_reg[PT_YM]) ?
                      sum_reg[PT_YM] - sum_reg[PT_YP] : sum_reg[PT_YP] - sum_reg[PT_YM];
            nv_reg <= nv_round[16] ? 16'hFFFF : nv_round[15:0];
            sq_side_reg  <= sq_side_next;
            sqx_reg      <= 62'(sq_side_next.ax) * 62'(sq_side_next.ax);
            sqy_reg      <= 62'(sq_side_next.ay) * 62'(sq_side_next.ay);
            ssq_reg      <= 64'(sqx_reg) + 64'(sqy_reg);
            ssq_side_reg <= sq_side_reg;
        end
    end

    fvng_isqrt u_isqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (pipe_en),
        .in_valid    (vld_reg[PRE_STAGES-1]),
        .in_radicand (ssq_reg),
        .in_side     (ssq_side_reg),
        .out_valid   (rt_valid),
        .out_root    (rt_root),
        .out_side    (rt_side)
    );

    fvng_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (rt_valid),
        .in_len    (rt_root),
        .in_side   (rt_side),
        .out_valid (nm_valid),
        .out_mag_x (nm_mag_x),
        .out_mag_y (nm_mag_y),
        .out_side  (nm_side)
    );

    // Sign and saturate the components, zero when flat
    always_comb
    begin
        if (nm_side.flat)
        begin
            gx_next = 16'd0;
            gy_next = 16'd0;
        end
        else
        begin
            if (nm_side.nx)
                gx_next = 16'd0 - ((nm_mag_x > 16'd32768) ? 16'd32768 : nm_mag_x);
            else
                gx_next = (nm_mag_x > 16'd32767) ? 16'd32767 : nm_mag_x;
            if (nm_side.ny)
                gy_next = 16'd0 - ((nm_mag_y > 16'd32768) ? 16'd32768 : nm_mag_y);
            else
                gy_next = (nm_mag_y > 16'd32767) ? 16'd32767 : nm_mag_y;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= nm_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            nv_out_reg   <= nm_side.nv;
            gx_out_reg   <= gx_next;
            gy_out_reg   <= gy_next;
            flat_out_reg <= nm_side.flat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = nv_out_reg;
    assign grad_x      = gx_out_reg;
    assign grad_y      = gy_out_reg;

`ifndef SYNTHESIS
    // Rounded quotient never exceeds one in Q1.15
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nm_valid |-> (nm_mag_x <= 16'd32768 && nm_mag_y <= 16'd32768))
        else $error("gradient quotient above one");

    // A unit vector has a component of at least 1/sqrt(2)
    a_unit_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !flat_out_reg) |->
            (gx_out_reg >= 16'sd23169 || gx_out_reg <= -16'sd23169 ||
             gy_out_reg >= 16'sd23169 || gy_out_reg <= -16'sd23169))
        else $error("normalized gradient too short");

    // A held output freezes the front of the root unit
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(vld_reg[PRE_STAGES-1]))
        else $error("pipeline moved while output held");
`endif

endmodule
`default_nettype wire
